// ===== src/binaural_chord_tone_mixer_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Binaural chord tone mixer assertion macros
// Shared concurrent assertion forms; compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef BINAURAL_CHORD_TONE_MIXER_UNIT_MACROS_SVH
`define BINAURAL_CHORD_TONE_MIXER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define BCTM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bctm assertion failed");

// next-cycle implication
`define BCTM_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bctm assertion failed");

`else

`define BCTM_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define BCTM_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== src/bctm_pkg.sv =====
// ----------------------------------------------------------------------------
// bctm_pkg
// Types, chord tables and mixing constants of the binaural chord tone mixer.
// ----------------------------------------------------------------------------
package bctm_pkg;

   localparam int NUM_CHORDS = 12;
   localparam int NUM_TONES  = 88;
   localparam int TONE_AW    = 7;
   localparam int CHORD_W    = 4;
   localparam int GAIN_W     = 10;
   localparam int SAMPLE_W   = 16;
   localparam int COUNT_W    = 4;
   localparam int MHZ_W      = 20;
   localparam int RG10_W     = 14;
   localparam int PROD_W     = 31;
   localparam int ACC_W      = 32;
   localparam int QUOT_W     = 16;
   localparam int RECIP_W      = 30;
   localparam int RECIP_SHIFT  = 42;
   localparam int RECIP_PROD_W = 59;

   localparam logic [CHORD_W-1:0] MAX_CHORD = 4'd11;

   // floor((v + 5115) / 10230) + 32768 == floor((v + MIX_BIAS) / 10230)
   localparam logic signed [ACC_W-1:0] MIX_BIAS    = 32'sd335221755;
   localparam logic signed [ACC_W-1:0] DIV_LIMIT   = 32'sd670433280;  // 10230 << 16
   localparam logic signed [ACC_W-1:0] DIV_MAX_REM = 32'sd670433279;

   // floor(w / 10230) == (floor(w / 2) * RECIP_M) >> 42 for 0 <= w < 2^30
   localparam logic [RECIP_W-1:0] RECIP_M = 30'd859833141;  // ceil(2^42 / 5115)

   typedef enum logic [1:0] {
      CSR_RIVER_GAIN   = 2'd0,
      CSR_TONE_GAIN    = 2'd1,
      CSR_CHORD_SELECT = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ALU_NOP,
      ALU_CLEAR,
      ALU_MAC,
      ALU_BIAS,
      ALU_CLAMP,
      ALU_RECIP
   } alu_op_type;

   typedef struct packed {
      alu_op_type                   op;
      logic signed [SAMPLE_W-1:0]   a;
      logic        [RG10_W-1:0]     b;
   } alu_cmd_type;

   typedef struct packed {
      logic                rd_en;
      logic                adv_en;
      logic [TONE_AW-1:0]  addr;
   } phase_cmd_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] river_left;
      logic signed [SAMPLE_W-1:0] river_right;
      logic                       river_present;
   } req_payload_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left_out;
      logic signed [SAMPLE_W-1:0] right_out;
   } rsp_payload_type;

   localparam logic [COUNT_W-1:0] LEFT_COUNT [NUM_CHORDS] =
      '{4'd1, 4'd1, 4'd1, 4'd1, 4'd6, 4'd8, 4'd3, 4'd2, 4'd7, 4'd6, 4'd6, 4'd2};
   localparam logic [COUNT_W-1:0] RIGHT_COUNT [NUM_CHORDS] =
      '{4'd1, 4'd1, 4'd1, 4'd1, 4'd6, 4'd8, 4'd3, 4'd2, 4'd7, 4'd6, 4'd6, 4'd2};
   localparam logic [TONE_AW-1:0] CHORD_BASE [NUM_CHORDS] =
      '{7'd0, 7'd2, 7'd4, 7'd6, 7'd8, 7'd20, 7'd36, 7'd42, 7'd46, 7'd60, 7'd72, 7'd84};

   // tone frequencies in millihertz; per chord: left tones, then right tones
   localparam logic [MHZ_W-1:0] TONE_MHZ [NUM_TONES] = '{
      20'd300000, 20'd310000,
      20'd300000, 20'd316000,
      20'd150000, 20'd152000,
      20'd150000, 20'd156000,
      20'd88200,  20'd176400, 20'd441000, 20'd529200, 20'd705600, 20'd882000,
      20'd94500,  20'd183400, 20'd463000, 20'd592200, 20'd775600, 20'd922000,
      20'd272200, 20'd332000, 20'd421300, 20'd289400, 20'd367500, 20'd442000,
      20'd295700, 20'd414700,
      20'd280530, 20'd340030, 20'd428830, 20'd297230, 20'd374830, 20'd449830,
      20'd303530, 20'd422530,
      20'd110000, 20'd250000, 20'd400000,
      20'd117830, 20'd270215, 20'd438000,
      20'd99500,  20'd202700,
      20'd101000, 20'd204200,
      20'd100000, 20'd200000, 20'd250000, 20'd300000, 20'd400000, 20'd500000,
      20'd600000,
      20'd101500, 20'd204000, 20'd254000, 20'd304000, 20'd410000, 20'd510100,
      20'd604800,
      20'd50000,  20'd400000, 20'd503000, 20'd600000, 20'd750000, 20'd900000,
      20'd50800,  20'd404000, 20'd507200, 20'd604000, 20'd754000, 20'd904000,
      20'd200000, 20'd250000, 20'd300000, 20'd600000, 20'd750000, 20'd900000,
      20'd204000, 20'd254000, 20'd304000, 20'd616200, 20'd765900, 20'd916200,
      20'd308000, 20'd500000,
      20'd322000, 20'd515000
   };

endpackage

// ===== src/bctm_phase_bank.sv =====
// ----------------------------------------------------------------------------
// bctm_phase_bank
// Per-tone phase accumulators: one read and one advance write per cycle.
// ----------------------------------------------------------------------------
module bctm_phase_bank
   import bctm_pkg::*;
#(
   parameter int SAMPLE_RATE = 44100,
   parameter int PHASE_BITS  = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  phase_cmd_type         cmd,
   output logic [PHASE_BITS-1:0] phase
);

   localparam logic [63:0] INC_DIV   = 64'd1000 * 64'(SAMPLE_RATE);
   localparam logic [63:0] INC_ROUND = 64'd500 * 64'(SAMPLE_RATE);

   typedef logic [PHASE_BITS-1:0] inc_tab_type [NUM_TONES];

   // increment = round(f * 2^PHASE_BITS / (1000 * SAMPLE_RATE)), f in millihertz
   function automatic inc_tab_type build_inc();
      inc_tab_type  tab;
      logic [63:0]  num;
      for (int k = 0; k < NUM_TONES; k++) begin
         num    = (64'(TONE_MHZ[k]) << PHASE_BITS) + INC_ROUND;
         tab[k] = PHASE_BITS'(num / INC_DIV);
      end
      return tab;
   endfunction

   localparam inc_tab_type INC_TAB = build_inc();

   logic [PHASE_BITS-1:0] mem [NUM_TONES];
   logic [NUM_TONES-1:0]  valid_ff;
   logic [PHASE_BITS-1:0] rd_ff;
   logic                  rd_valid_ff;

   // never-written entries read as the reset phase of zero
   assign phase = rd_valid_ff ? rd_ff : '0;

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_ff <= mem[cmd.addr];
      end
      if (cmd.adv_en) begin
         mem[cmd.addr] <= phase + INC_TAB[cmd.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (cmd.adv_en) begin
            valid_ff[cmd.addr] <= 1'b1;
         end
         if (cmd.rd_en) begin
            rd_valid_ff <= valid_ff[cmd.addr];
         end
      end
   end

endmodule

// ===== src/bctm_sine_rom.sv =====
// ----------------------------------------------------------------------------
// bctm_sine_rom
// Q1.15 sine table built at elaboration, registered read.
// ----------------------------------------------------------------------------
module bctm_sine_rom
   import bctm_pkg::*;
#(
   parameter int SINE_TABLE_BITS = 10
) (
   input  logic                       clock,
   input  logic [SINE_TABLE_BITS-1:0] addr,
   output logic signed [SAMPLE_W-1:0] sine
);

   localparam int SINE_SIZE    = 1 << SINE_TABLE_BITS;
   localparam int QUARTER_BITS = SINE_TABLE_BITS - 2;

   localparam logic [63:0] CA = 64'd1686629713;
   localparam logic [63:0] CB = 64'd688904866;
   localparam logic [63:0] CC = 64'd76016977;

   typedef logic signed [SAMPLE_W-1:0] sine_tab_type [SINE_SIZE];

   // odd polynomial in Q30, each product truncated, rounded half up to Q1.15
   function automatic logic [SAMPLE_W-1:0] quarter_sine(input logic [63:0] u);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        x3;
      logic [63:0]        x5;
      logic [63:0]        r;
      logic signed [63:0] s;
      x  = u << (30 - QUARTER_BITS);
      x2 = (x * x) >> 30;
      x3 = (x2 * x) >> 30;
      x5 = (x3 * x2) >> 30;
      s  = $signed((CA * x) >> 30) - $signed((CB * x3) >> 30)
         + $signed((CC * x5) >> 30);
      if (s < 0) begin
         s = '0;
      end
      r = 64'(s + 64'sd16384) >> 15;
      if (r > 64'd32767) begin
         r = 64'd32767;
      end
      return r[SAMPLE_W-1:0];
   endfunction

   function automatic sine_tab_type build_sine();
      sine_tab_type         tab;
      logic [63:0]          quad;
      logic [63:0]          rr;
      logic [63:0]          u;
      logic [SAMPLE_W-1:0]  s;
      for (int k = 0; k < SINE_SIZE; k++) begin
         quad = 64'(k) >> QUARTER_BITS;
         rr   = 64'(k) & ((64'd1 << QUARTER_BITS) - 64'd1);
         u    = quad[0] ? (64'd1 << QUARTER_BITS) - rr : rr;
         s    = quarter_sine(u);
         tab[k] = quad[1] ? -$signed(s) : $signed(s);
      end
      return tab;
   endfunction

   localparam sine_tab_type SINE_TAB = build_sine();

   logic signed [SAMPLE_W-1:0] sine_ff;

   always_ff @(posedge clock) begin
      sine_ff <= SINE_TAB[addr];
   end

   assign sine = sine_ff;

endmodule

// ===== src/bctm_mac_unit.sv =====
// ----------------------------------------------------------------------------
// bctm_mac_unit
// Shared multiply-accumulate with clamp and reciprocal divide by 10230.
// ----------------------------------------------------------------------------
module bctm_mac_unit
   import bctm_pkg::*;
(
   input  logic              clock,
   input  alu_cmd_type       cmd,
   output logic [QUOT_W-1:0] quot
);

   logic signed [ACC_W-1:0]        acc_ff;
   logic signed [ACC_W-1:0]        acc_in;
   logic        [QUOT_W-1:0]       quot_ff;
   logic        [QUOT_W-1:0]       quot_in;
   logic signed [PROD_W-1:0]       prod;
   logic        [RECIP_PROD_W-1:0] recip_prod;

   assign prod       = cmd.a * $signed({1'b0, cmd.b});
   // clamped accumulator is below 2^30: halve it, then scale by 1/5115
   assign recip_prod = RECIP_PROD_W'(acc_ff[ACC_W-3:1]) * RECIP_PROD_W'(RECIP_M);

   always_comb begin
      acc_in  = acc_ff;
      quot_in = quot_ff;
      case (cmd.op)
         ALU_CLEAR: begin
            acc_in = '0;
         end
         ALU_MAC: begin
            acc_in = acc_ff + ACC_W'(prod);
         end
         ALU_BIAS: begin
            acc_in = acc_ff + MIX_BIAS;
         end
         ALU_CLAMP: begin
            // below zero gives quotient 0, at or above the limit gives all ones
            if (acc_ff[ACC_W-1]) begin
               acc_in = '0;
            end else if (acc_ff >= DIV_LIMIT) begin
               acc_in = DIV_MAX_REM;
            end
         end
         ALU_RECIP: begin
            quot_in = recip_prod[RECIP_SHIFT +: QUOT_W];
         end
         default: begin
            acc_in  = acc_ff;
            quot_in = quot_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      quot_ff <= quot_in;
   end

   assign quot = quot_ff;

endmodule

// ===== src/binaural_chord_tone_mixer_unit.sv =====
// ----------------------------------------------------------------------------
// binaural_chord_tone_mixer_unit
// Mixes a background stereo sample with the sine tones of a selected chord.
// ----------------------------------------------------------------------------
// Each request makes one stereo frame. A sequencer runs both sides through a
// single multiply-accumulate unit: per side a clear step, then for each tone
// a phase read, a sine lookup and phase advance, and a MAC, then background
// MAC, bias, clamp, one reciprocal-multiply divide and a result step. The
// req_stall output is high from acceptance until the sequencer is back in
// idle, so a new request is taken only once the sequencer has finished the
// last frame. The phase store needs no clearing pass after reset. A
// finished frame waits in the response register, and the next request is
// taken meanwhile; a second finished frame holds the block until it drains.
`include "binaural_chord_tone_mixer_unit_macros.svh"

module binaural_chord_tone_mixer_unit
   import bctm_pkg::*;
#(
   parameter int SAMPLE_RATE        = 44100,
   parameter int PHASE_BITS         = 24,
   parameter int SINE_TABLE_BITS    = 10,
   parameter int MAX_TONES_PER_SIDE = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  req_payload_type     req_payload,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rsp_payload_type     rsp_payload,
   input  logic                csr_wr_en,
   input  logic [1:0]          csr_index,
   input  logic [GAIN_W-1:0]   csr_wr_data
);

   localparam int CNT_W = $clog2(MAX_TONES_PER_SIDE + 1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_READ,
      ST_LOOKUP,
      ST_ACCUM,
      ST_RIVER,
      ST_BIAS,
      ST_CLAMP,
      ST_DIVIDE,
      ST_DONE
   } state_type;

   function automatic logic [CNT_W-1:0] side_count(input logic [COUNT_W-1:0] cnt);
      if (int'(cnt) < MAX_TONES_PER_SIDE) begin
         return CNT_W'(cnt);
      end
      return CNT_W'(MAX_TONES_PER_SIDE);
   endfunction

   // configuration
   logic [GAIN_W-1:0]  river_gain_ff;
   logic [GAIN_W-1:0]  tone_gain_ff;
   logic [CHORD_W-1:0] chord_sel_ff;

   state_type              state_ff,     state_in;
   logic                   side_ff,      side_in;
   logic [TONE_AW-1:0]     tone_addr_ff, tone_addr_in;
   logic [CNT_W-1:0]       tone_cnt_ff,  tone_cnt_in;
   logic [CNT_W-1:0]       tone_n_ff,    tone_n_in;
   logic [CHORD_W-1:0]     chord_ff,     chord_in;
   req_payload_type        req_ff,       req_in;
   logic [SAMPLE_W-1:0]    left_ff,      left_in;
   rsp_payload_type        rsp_ff,       rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic [CHORD_W-1:0]         chord_now;
   logic [RG10_W-1:0]          river_gain10;
   logic [SAMPLE_W-1:0]        result;
   alu_cmd_type                alu_cmd;
   phase_cmd_type              phase_cmd;
   logic [PHASE_BITS-1:0]      phase;
   logic signed [SAMPLE_W-1:0] sine;
   logic [QUOT_W-1:0]          quot;

   assign chord_now    = (chord_sel_ff > MAX_CHORD) ? MAX_CHORD : chord_sel_ff;
   assign river_gain10 = RG10_W'({river_gain_ff, 3'b000}) + RG10_W'({river_gain_ff, 1'b0});
   // quotient is offset by 32768: flipping the top bit removes it
   assign result       = {~quot[QUOT_W-1], quot[QUOT_W-2:0]};

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         river_gain_ff <= 10'd512;
         tone_gain_ff  <= 10'd512;
         chord_sel_ff  <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_RIVER_GAIN:   river_gain_ff <= csr_wr_data;
            CSR_TONE_GAIN:    tone_gain_ff  <= csr_wr_data;
            CSR_CHORD_SELECT: chord_sel_ff  <= csr_wr_data[CHORD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      side_in      = side_ff;
      tone_addr_in = tone_addr_ff;
      tone_cnt_in  = tone_cnt_ff;
      tone_n_in    = tone_n_ff;
      chord_in     = chord_ff;
      req_in       = req_ff;
      left_in      = left_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      alu_cmd      = '{op: ALU_NOP, a: '0, b: '0};
      phase_cmd    = '{rd_en: 1'b0, adv_en: 1'b0, addr: tone_addr_ff};

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in       = req_payload;
               chord_in     = chord_now;
               side_in      = 1'b0;
               tone_addr_in = CHORD_BASE[chord_now];
               tone_n_in    = side_count(LEFT_COUNT[chord_now]);
               tone_cnt_in  = '0;
               state_in     = ST_CLEAR;
            end
         end
         ST_CLEAR: begin
            alu_cmd.op  = ALU_CLEAR;
            tone_cnt_in = '0;
            state_in    = (tone_n_ff == '0) ? ST_RIVER : ST_READ;
         end
         ST_READ: begin
            phase_cmd.rd_en = 1'b1;
            state_in        = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            // sine table latches the phase now; the phase moves on behind it
            phase_cmd.adv_en = 1'b1;
            state_in         = ST_ACCUM;
         end
         ST_ACCUM: begin
            alu_cmd      = '{op: ALU_MAC, a: sine, b: RG10_W'(tone_gain_ff)};
            tone_addr_in = tone_addr_ff + 1'b1;
            tone_cnt_in  = tone_cnt_ff + 1'b1;
            state_in     = (CNT_W'(tone_cnt_ff + 1'b1) == tone_n_ff) ? ST_RIVER : ST_READ;
         end
         ST_RIVER: begin
            if (req_ff.river_present) begin
               alu_cmd = '{op: ALU_MAC,
                           a: side_ff ? req_ff.river_right : req_ff.river_left,
                           b: river_gain10};
            end
            state_in = ST_BIAS;
         end
         ST_BIAS: begin
            alu_cmd.op = ALU_BIAS;
            state_in   = ST_CLAMP;
         end
         ST_CLAMP: begin
            alu_cmd.op = ALU_CLAMP;
            state_in   = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            alu_cmd.op = ALU_RECIP;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            if (!side_ff) begin
               left_in      = result;
               side_in      = 1'b1;
               tone_addr_in = CHORD_BASE[chord_ff] + TONE_AW'(LEFT_COUNT[chord_ff]);
               tone_n_in    = side_count(RIGHT_COUNT[chord_ff]);
               tone_cnt_in  = '0;
               state_in     = ST_CLEAR;
            end else if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in       = '{left_out: left_ff, right_out: result};
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         side_ff      <= 1'b0;
         tone_addr_ff <= '0;
         tone_cnt_ff  <= '0;
         tone_n_ff    <= '0;
         chord_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         side_ff      <= side_in;
         tone_addr_ff <= tone_addr_in;
         tone_cnt_ff  <= tone_cnt_in;
         tone_n_ff    <= tone_n_in;
         chord_ff     <= chord_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff  <= req_in;
      left_ff <= left_in;
      rsp_ff  <= rsp_in;
   end

   bctm_phase_bank #(
      .SAMPLE_RATE (SAMPLE_RATE),
      .PHASE_BITS  (PHASE_BITS)
   ) u_phase_bank (
      .clock (clock),
      .reset (reset),
      .cmd   (phase_cmd),
      .phase (phase)
   );

   bctm_sine_rom #(
      .SINE_TABLE_BITS (SINE_TABLE_BITS)
   ) u_sine_rom (
      .clock (clock),
      .addr  (phase[PHASE_BITS-1 -: SINE_TABLE_BITS]),
      .sine  (sine)
   );

   bctm_mac_unit u_mac_unit (
      .clock (clock),
      .cmd   (alu_cmd),
      .quot  (quot)
   );

   `BCTM_ASSERT_IMP(a_tone_cnt_bound, clock, reset, state_ff != ST_IDLE, tone_cnt_ff <= tone_n_ff)
   `BCTM_ASSERT_IMP(a_phase_addr_range, clock, reset, phase_cmd.rd_en || phase_cmd.adv_en, phase_cmd.addr < TONE_AW'(NUM_TONES))
   `BCTM_ASSERT_NXT(a_accept_busy, clock, reset, req_valid && !req_stall, state_ff != ST_IDLE)
   `BCTM_ASSERT_IMP(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff), $past(state_ff == ST_DONE && side_ff))

endmodule

// ===== bench/binaural_chord_tone_mixer_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binaural_chord_tone_mixer_unit_tb
// Self-checking bench: a short table of directed frames, then random frames
// under three sender/receiver idle mixes. A bit-exact model of the tone bank
// and mixer predicts each unpinned stereo frame; results are checked in order.
// ----------------------------------------------------------------------------
module binaural_chord_tone_mixer_unit_tb;
   import bctm_pkg::*;

   localparam int CHORD_SLOTS  = 12;
   localparam int TONE_SLOTS   = 88;
   localparam int PHASE_W      = 24;
   localparam int SINE_AW      = 10;
   localparam int TONES_MAX    = 8;
   localparam int FRAME_SLACK  = 100;
   localparam int CYCLE_LIMIT  = 2000000;
   localparam int RANDOM_ITEMS = 1500;

   localparam int CHORD_TONES [CHORD_SLOTS] = '{1, 1, 1, 1, 6, 8, 3, 2, 7, 6, 6, 2};

   localparam int unsigned FREQ_MHZ [TONE_SLOTS] = '{
      300000, 310000,
      300000, 316000,
      150000, 152000,
      150000, 156000,
      88200, 176400, 441000, 529200, 705600, 882000,
      94500, 183400, 463000, 592200, 775600, 922000,
      272200, 332000, 421300, 289400, 367500, 442000, 295700, 414700,
      280530, 340030, 428830, 297230, 374830, 449830, 303530, 422530,
      110000, 250000, 400000,
      117830, 270215, 438000,
      99500, 202700,
      101000, 204200,
      100000, 200000, 250000, 300000, 400000, 500000, 600000,
      101500, 204000, 254000, 304000, 410000, 510100, 604800,
      50000, 400000, 503000, 600000, 750000, 900000,
      50800, 404000, 507200, 604000, 754000, 904000,
      200000, 250000, 300000, 600000, 750000, 900000,
      204000, 254000, 304000, 616200, 765900, 916200,
      308000, 500000,
      322000, 515000
   };

   typedef struct {
      int              river_gain;
      int              tone_gain;
      int              chord;
      req_payload_type request;
      bit              pinned;
      rsp_payload_type pinned_frame;
   } frame_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   req_payload_type     req_payload = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   rsp_payload_type     rsp_payload;
   logic                csr_wr_en = 1'b0;
   logic [1:0]          csr_index = CSR_RIVER_GAIN;
   logic [GAIN_W-1:0]   csr_wr_data = '0;

   // model state
   int                  sine_table [1 << SINE_AW];
   logic [PHASE_W-1:0]  tone_step  [TONE_SLOTS];
   logic [PHASE_W-1:0]  tone_phase [TONE_SLOTS];
   int                  chord_base [CHORD_SLOTS];
   int                  river_gain_reg;
   int                  tone_gain_reg;
   int                  chord_reg;

   rsp_payload_type     pending_frames [$];
   rsp_payload_type     expected_frame;
   frame_row_type       directed_rows [$];
   int                  mismatch_count = 0;
   int                  cycle_count = 0;
   int                  send_idle_pct = 13;
   int                  recv_idle_pct = 74;

   binaural_chord_tone_mixer_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int quarter_sine(int u);
      longint unsigned x, x2, x3, x5;
      longint s, r;
      x  = longint'(u) << (30 - (SINE_AW - 2));
      x2 = (x * x) >> 30;
      x3 = (x2 * x) >> 30;
      x5 = (x3 * x2) >> 30;
      s  = longint'((64'd1686629713 * x) >> 30) - longint'((64'd688904866 * x3) >> 30)
         + longint'((64'd76016977 * x5) >> 30);
      if (s < 0) s = 0;
      r = (s + 16384) / 32768;
      if (r > 32767) r = 32767;
      return int'(r);
   endfunction

   function automatic void reset_model();
      int quad, pos, u, s, acc;
      longint unsigned num;
      for (int k = 0; k < (1 << SINE_AW); k++) begin
         quad = k >> (SINE_AW - 2);
         pos  = k & ((1 << (SINE_AW - 2)) - 1);
         u    = (quad & 1) ? (1 << (SINE_AW - 2)) - pos : pos;
         s    = quarter_sine(u);
         sine_table[k] = (quad & 2) ? -s : s;
      end
      acc = 0;
      for (int c = 0; c < CHORD_SLOTS; c++) begin
         chord_base[c] = acc;
         acc += 2 * CHORD_TONES[c];
      end
      for (int k = 0; k < TONE_SLOTS; k++) begin
         num = (longint'(FREQ_MHZ[k]) << PHASE_W) + 64'd22050000;
         tone_step[k]  = PHASE_W'(num / 64'd44100000);
         tone_phase[k] = '0;
      end
      river_gain_reg = 512;
      tone_gain_reg  = 512;
      chord_reg      = 0;
   endfunction

   // sounds tones first..first+n-1 at their current phase, then advances them
   function automatic longint sum_tones(int first, int n);
      longint acc;
      acc = 0;
      for (int j = 0; j < n; j++) begin
         acc += sine_table[tone_phase[first + j][PHASE_W-1 -: SINE_AW]];
         tone_phase[first + j] = tone_phase[first + j] + tone_step[first + j];
      end
      return acc;
   endfunction

   function automatic logic signed [15:0] to_q15(longint v);
      longint q;
      // offset keeps the division on positive numbers, so it floors
      q = (v + 5115 + 64'sd10230 * 1048576) / 10230 - 1048576;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q[15:0];
   endfunction

   function automatic rsp_payload_type mix_frame(req_payload_type rq);
      int ch, n;
      longint vl, vr;
      rsp_payload_type r;
      ch = (chord_reg > CHORD_SLOTS - 1) ? CHORD_SLOTS - 1 : chord_reg;
      n  = (CHORD_TONES[ch] < TONES_MAX) ? CHORD_TONES[ch] : TONES_MAX;
      vl = 0;
      vr = 0;
      if (rq.river_present) begin
         vl = longint'($signed(rq.river_left)) * river_gain_reg * 10;
         vr = longint'($signed(rq.river_right)) * river_gain_reg * 10;
      end
      vl += sum_tones(chord_base[ch], n) * tone_gain_reg;
      vr += sum_tones(chord_base[ch] + CHORD_TONES[ch], n) * tone_gain_reg;
      r.left_out  = to_q15(vl);
      r.right_out = to_q15(vr);
      return r;
   endfunction

   task automatic note_failure(string what, int exp_val, int act_val);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch %s: expected %0d, got %0d", what, exp_val, act_val);
   endtask

   task automatic add_row(int rg, int tg, int ch, logic [15:0] left, logic [15:0] right,
                          bit present, bit pinned, logic [15:0] exp_l, logic [15:0] exp_r);
      frame_row_type row;
      row.river_gain              = rg;
      row.tone_gain               = tg;
      row.chord                   = ch;
      row.request.river_left      = left;
      row.request.river_right     = right;
      row.request.river_present   = present;
      row.pinned                  = pinned;
      row.pinned_frame.left_out   = exp_l;
      row.pinned_frame.right_out  = exp_r;
      directed_rows.push_back(row);
   endtask

   // called just after the clock rises; returns just after the request is accepted
   task automatic send_request(req_payload_type rq, bit pinned, rsp_payload_type pinned_frame);
      rsp_payload_type predicted;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= rq;
      do @(posedge clock); while (req_stall);
      predicted = mix_frame(rq);
      pending_frames.push_back(pinned ? pinned_frame : predicted);
   endtask

   task automatic drain_frames();
      req_valid <= 1'b0;
      while (pending_frames.size() != 0) @(posedge clock);
      repeat (FRAME_SLACK) @(posedge clock);
   endtask

   task automatic apply_config(int rg, int tg, int ch);
      drain_frames();
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_RIVER_GAIN;
      csr_wr_data <= GAIN_W'(rg);
      @(posedge clock);
      river_gain_reg = rg;
      csr_index   <= CSR_TONE_GAIN;
      csr_wr_data <= GAIN_W'(tg);
      @(posedge clock);
      tone_gain_reg = tg;
      csr_index   <= CSR_CHORD_SELECT;
      csr_wr_data <= GAIN_W'(ch);
      @(posedge clock);
      chord_reg = ch;
      csr_wr_en <= 1'b0;
   endtask

   function automatic int pick_gain();
      case ($urandom_range(5))
         0:       return 0;
         1:       return 1023;
         default: return $urandom_range(1023);
      endcase
   endfunction

   function automatic logic [15:0] pick_sample();
      case ($urandom_range(7))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         2:       return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   always @(posedge clock) begin
      rsp_stall <= reset ? 1'b0 : ($urandom_range(99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_frames.size() == 0) begin
            note_failure("unexpected frame, left", 0, $signed(rsp_payload.left_out));
         end else begin
            expected_frame = pending_frames.pop_front();
            if (rsp_payload.left_out !== expected_frame.left_out)
               note_failure("left_out", $signed(expected_frame.left_out),
                            $signed(rsp_payload.left_out));
            if (rsp_payload.right_out !== expected_frame.right_out)
               note_failure("right_out", $signed(expected_frame.right_out),
                            $signed(rsp_payload.right_out));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      req_payload_type rq;
      rsp_payload_type none;
      none = '0;
      reset_model();

      // first frame after reset: all phases at zero, so tones add nothing
      add_row(512, 512, 0, 16'h1234, 16'hEDCB, 1'b0, 1'b1, 16'h0000, 16'h0000);
      add_row(512, 512, 0, 16'h7FFF, 16'h8000, 1'b1, 1'b0, '0, '0);
      add_row(512, 512, 0, 16'h8000, 16'h7FFF, 1'b1, 1'b0, '0, '0);
      // full background gain, tones muted: samples pass straight through
      add_row(1023, 0, 0, 16'h7FFF, 16'h8000, 1'b1, 1'b1, 16'h7FFF, 16'h8000);
      add_row(1023, 0, 0, 16'h0001, 16'hFFFF, 1'b1, 1'b1, 16'h0001, 16'hFFFF);
      add_row(1023, 0, 0, 16'h5555, 16'hAAAA, 1'b1, 1'b1, 16'h5555, 16'hAAAA);
      // pair absent, or background and tone gains zero: samples ignored
      add_row(1023, 0, 0, 16'h7FFF, 16'h7FFF, 1'b0, 1'b1, 16'h0000, 16'h0000);
      add_row(0, 0, 3, 16'h8000, 16'h7FFF, 1'b1, 1'b1, 16'h0000, 16'h0000);
      // largest chord at full tone gain, background at both extremes and then off
      add_row(1023, 1023, 5, 16'h7FFF, 16'h7FFF, 1'b1, 1'b0, '0, '0);
      add_row(1023, 1023, 5, 16'h8000, 16'h8000, 1'b1, 1'b0, '0, '0);
      add_row(0, 1023, 5, 16'h0000, 16'h0000, 1'b1, 1'b0, '0, '0);
      // chord index past the last chord, then the last chord itself
      add_row(0, 1023, 12, 16'h0000, 16'h0000, 1'b1, 1'b0, '0, '0);
      add_row(0, 1023, 13, 16'h0000, 16'h0000, 1'b0, 1'b0, '0, '0);
      add_row(0, 1023, 14, 16'h0000, 16'h0000, 1'b0, 1'b0, '0, '0);
      add_row(0, 1023, 15, 16'h0000, 16'h0000, 1'b0, 1'b0, '0, '0);
      add_row(0, 1023, 11, 16'h0000, 16'h0000, 1'b0, 1'b0, '0, '0);
      add_row(300, 700, 1, 16'h4000, 16'hC000, 1'b1, 1'b0, '0, '0);
      add_row(300, 700, 2, 16'h2000, 16'hE000, 1'b1, 1'b0, '0, '0);
      add_row(300, 700, 4, 16'h1000, 16'hF000, 1'b1, 1'b0, '0, '0);
      add_row(300, 700, 6, 16'h0800, 16'hF800, 1'b1, 1'b0, '0, '0);
      add_row(300, 700, 7, 16'h0400, 16'hFC00, 1'b1, 1'b0, '0, '0);
      add_row(300, 700, 8, 16'h0200, 16'hFE00, 1'b1, 1'b0, '0, '0);
      add_row(300, 700, 9, 16'h0100, 16'hFF00, 1'b1, 1'b0, '0, '0);
      add_row(300, 700, 10, 16'h0080, 16'hFF80, 1'b1, 1'b0, '0, '0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].river_gain != river_gain_reg ||
             directed_rows[i].tone_gain != tone_gain_reg ||
             directed_rows[i].chord != chord_reg)
            apply_config(directed_rows[i].river_gain, directed_rows[i].tone_gain,
                         directed_rows[i].chord);
         send_request(directed_rows[i].request, directed_rows[i].pinned,
                      directed_rows[i].pinned_frame);
      end

      for (int mix = 0; mix < 3; mix++) begin
         send_idle_pct = (mix == 0) ? 13 : (mix == 1) ? 74 : 0;
         recv_idle_pct = (mix == 0) ? 74 : (mix == 1) ? 13 : 0;
         for (int i = 0; i < RANDOM_ITEMS / 3; i++) begin
            if (i % 60 == 0)
               apply_config(pick_gain(), pick_gain(), $urandom_range(15));
            rq.river_left    = pick_sample();
            rq.river_right   = pick_sample();
            rq.river_present = ($urandom_range(9) != 0);
            send_request(rq, 1'b0, none);
         end
      end

      drain_frames();
      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
